### sv/multi_slot_token_bucket_defines.svh
// ----------------------------------------------------------------------------
// multi_slot_token_bucket_defines.svh
// Assertion macros shared by the token bucket checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_TOKEN_BUCKET_DEFINES_SVH
`define MULTI_SLOT_TOKEN_BUCKET_DEFINES_SVH

// same-cycle implication
`define MSTB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("token bucket assertion failed");

// next-cycle implication
`define MSTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("token bucket assertion failed");

`endif

### sv/mstb_pkg.sv
// ----------------------------------------------------------------------------
// mstb_pkg
// Types and constants of the multi slot token bucket.
// ----------------------------------------------------------------------------
package mstb_pkg;

   localparam int SLOTS_DEF       = 16;
   localparam int TOKEN_WIDTH_DEF = 20;

   localparam int FUNC_W  = 2;
   localparam int SLOT_W  = 4;
   localparam int FIELD_W = 20;
   localparam int STAT_W  = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_OPEN    = 2'd1,
      FUNC_CLOSE   = 2'd2,
      FUNC_CONSUME = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOT_OPEN = 2'd2
   } status_type;

   typedef struct packed {
      logic tick;
      logic open;
      logic close;
      logic take;
   } lane_ctl_type;

endpackage

### sv/mstb_lane.sv
// ----------------------------------------------------------------------------
// mstb_lane
// One bucket: open flag, rate, burst and token count with its update.
// ----------------------------------------------------------------------------
module mstb_lane #(
   parameter int TOKEN_WIDTH = mstb_pkg::TOKEN_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mstb_pkg::lane_ctl_type     ctl,
   input  logic [TOKEN_WIDTH-1:0]     rate,
   input  logic [TOKEN_WIDTH-1:0]     burst,
   input  logic [TOKEN_WIDTH-1:0]     grant,
   output logic                       is_open,
   output logic [TOKEN_WIDTH-1:0]     tokens,
   output logic [TOKEN_WIDTH-1:0]     tokens_tick
);

   logic                   open_ff, open_in;
   logic [TOKEN_WIDTH-1:0] rate_ff, rate_in;
   logic [TOKEN_WIDTH-1:0] burst_ff, burst_in;
   logic [TOKEN_WIDTH-1:0] tok_ff, tok_in;
   logic [TOKEN_WIDTH:0]   sum;

   assign sum         = {1'b0, tok_ff} + {1'b0, rate_ff};
   assign tokens_tick = (sum > {1'b0, burst_ff}) ? burst_ff : sum[TOKEN_WIDTH-1:0];

   always_comb begin
      open_in  = open_ff;
      rate_in  = rate_ff;
      burst_in = burst_ff;
      tok_in   = tok_ff;
      if (ctl.open) begin
         open_in  = 1'b1;
         rate_in  = rate;
         burst_in = burst;
         tok_in   = '0;
      end else if (ctl.close) begin
         open_in = 1'b0;
      end else if (ctl.tick && open_ff) begin
         tok_in = tokens_tick;
      end else if (ctl.take) begin
         tok_in = tok_ff - grant;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff  <= rate_in;
      burst_ff <= burst_in;
      tok_ff   <= tok_in;
   end

   assign is_open = open_ff;
   assign tokens  = tok_ff;

endmodule

### sv/mstb_alloc.sv
// ----------------------------------------------------------------------------
// mstb_alloc
// Finds the lowest slot that is not open.
// ----------------------------------------------------------------------------
module mstb_alloc #(
   parameter int SLOTS = mstb_pkg::SLOTS_DEF,
   parameter int IDX_W = 4
) (
   input  logic [SLOTS-1:0]  open_vec,
   output logic              found,
   output logic [IDX_W-1:0]  idx
);

   always_comb begin
      found = 1'b0;
      idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!open_vec[i]) begin
            found = 1'b1;
            idx   = IDX_W'(i);
         end
      end
   end

endmodule

### sv/multi_slot_token_bucket.sv
// ----------------------------------------------------------------------------
// multi_slot_token_bucket
// Table of token buckets with tick, open, close and consume requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. busy stays low,
//   so one request can be issued every cycle.
//   The request is registered, then processed against the slot table in the
//   next cycle; slot state and the response register update at the end of
//   that cycle. rsp_valid is high for one cycle, driven from the response register.
//   Throughput: one request per cycle. Every request returns exactly
//   one response.
//   A tick updates all open slots in parallel; the other requests touch one
//   slot. Back-to-back requests see the state left by the previous one.
//   Reset clears all open flags and the pipeline valids; bucket contents
//   are written by open before use.
//   The response cannot be stalled: the receiver must take rsp_* in the
//   cycle rsp_valid is high.
// ----------------------------------------------------------------------------
module multi_slot_token_bucket #(
   parameter int SLOTS       = mstb_pkg::SLOTS_DEF,
   parameter int TOKEN_WIDTH = mstb_pkg::TOKEN_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mstb_pkg::FUNC_W-1:0]   req_func,
   input  logic [mstb_pkg::SLOT_W-1:0]   req_slot,
   input  logic [mstb_pkg::FIELD_W-1:0]  req_rate,
   input  logic [mstb_pkg::FIELD_W-1:0]  req_burst_limit,
   input  logic [mstb_pkg::FIELD_W-1:0]  req_request_size,
   output logic                          rsp_valid,
   output logic [mstb_pkg::STAT_W-1:0]   rsp_status,
   output logic [mstb_pkg::SLOT_W-1:0]   rsp_slot_out,
   output logic [mstb_pkg::FIELD_W-1:0]  rsp_granted,
   output logic [mstb_pkg::FIELD_W-1:0]  rsp_tokens_left
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TW    = TOKEN_WIDTH;
   localparam int CW    = (TW > mstb_pkg::FIELD_W) ? TW : mstb_pkg::FIELD_W;

   // request register
   logic                          in_valid_ff, in_valid_in;
   mstb_pkg::func_type            func_ff;
   logic [mstb_pkg::SLOT_W-1:0]   slot_ff;
   logic [TW-1:0]                 rate_ff, burst_ff;
   logic [mstb_pkg::FIELD_W-1:0]  size_ff;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   mstb_pkg::status_type          status_ff, status_in;
   logic [mstb_pkg::SLOT_W-1:0]   slot_out_ff, slot_out_in;
   logic [mstb_pkg::FIELD_W-1:0]  granted_ff, granted_in;
   logic [mstb_pkg::FIELD_W-1:0]  left_ff, left_in;

   mstb_pkg::lane_ctl_type        lane_ctl [SLOTS];
   logic [SLOTS-1:0]              lane_open;
   logic [TW-1:0]                 lane_tok  [SLOTS];
   logic [TW-1:0]                 lane_tick [SLOTS];

   logic                          free_found;
   logic [IDX_W-1:0]              free_idx;
   logic [IDX_W-1:0]              sel_idx;
   logic                          in_range, sel_ok;
   logic [TW-1:0]                 sel_tok, sel_tick;
   logic [CW-1:0]                 size_cw, tok_cw, grant_cw;
   logic [TW-1:0]                 grant, tok_after;

   assign busy        = 1'b0;
   assign in_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         func_ff  <= mstb_pkg::func_type'(req_func);
         slot_ff  <= req_slot;
         rate_ff  <= TW'(req_rate);
         burst_ff <= TW'(req_burst_limit);
         size_ff  <= req_request_size;
      end
      status_ff   <= status_in;
      slot_out_ff <= slot_out_in;
      granted_ff  <= granted_in;
      left_ff     <= left_in;
   end

   mstb_alloc #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_alloc (
      .open_vec (lane_open),
      .found    (free_found),
      .idx      (free_idx)
   );

   // slot selection
   assign sel_idx  = IDX_W'(slot_ff);
   assign in_range = 32'(slot_ff) < 32'(SLOTS);
   assign sel_ok   = in_range && lane_open[sel_idx];
   assign sel_tok  = in_range ? lane_tok[sel_idx]  : '0;
   assign sel_tick = in_range ? lane_tick[sel_idx] : '0;

   assign size_cw   = CW'(size_ff);
   assign tok_cw    = CW'(sel_tok);
   assign grant_cw  = (size_cw < tok_cw) ? size_cw : tok_cw;
   assign grant     = TW'(grant_cw);
   assign tok_after = sel_tok - grant;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         lane_ctl[i].tick  = in_valid_ff && (func_ff == mstb_pkg::FUNC_TICK);
         lane_ctl[i].open  = in_valid_ff && (func_ff == mstb_pkg::FUNC_OPEN) &&
                             free_found && (free_idx == IDX_W'(i));
         lane_ctl[i].close = in_valid_ff && (func_ff == mstb_pkg::FUNC_CLOSE) &&
                             sel_ok && (sel_idx == IDX_W'(i));
         lane_ctl[i].take  = in_valid_ff && (func_ff == mstb_pkg::FUNC_CONSUME) &&
                             sel_ok && (sel_idx == IDX_W'(i));
      end
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_lane
      mstb_lane #(
         .TOKEN_WIDTH (TW)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctl         (lane_ctl[g]),
         .rate        (rate_ff),
         .burst       (burst_ff),
         .grant       (grant),
         .is_open     (lane_open[g]),
         .tokens      (lane_tok[g]),
         .tokens_tick (lane_tick[g])
      );
   end

   // response
   always_comb begin
      rsp_valid_in = in_valid_ff;
      status_in    = mstb_pkg::ST_OK;
      slot_out_in  = slot_ff;
      granted_in   = '0;
      left_in      = '0;
      case (func_ff)
         mstb_pkg::FUNC_TICK: begin
            left_in = sel_ok ? mstb_pkg::FIELD_W'(sel_tick) : '0;
         end
         mstb_pkg::FUNC_OPEN: begin
            if (free_found) begin
               slot_out_in = mstb_pkg::SLOT_W'(free_idx);
            end else begin
               status_in   = mstb_pkg::ST_FULL;
               slot_out_in = '0;
            end
         end
         mstb_pkg::FUNC_CLOSE: begin
            if (!sel_ok) begin
               status_in = mstb_pkg::ST_NOT_OPEN;
            end
         end
         mstb_pkg::FUNC_CONSUME: begin
            if (!sel_ok) begin
               status_in = mstb_pkg::ST_NOT_OPEN;
            end else begin
               granted_in = mstb_pkg::FIELD_W'(grant);
               left_in    = mstb_pkg::FIELD_W'(tok_after);
            end
         end
         default: begin
            status_in = mstb_pkg::ST_NOT_OPEN;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_slot_out    = slot_out_ff;
   assign rsp_granted     = granted_ff;
   assign rsp_tokens_left = left_ff;

endmodule

### sv/mstb_checker.sv
// ----------------------------------------------------------------------------
// mstb_port_checker
// Port-level checks of the token bucket, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_slot_token_bucket_defines.svh"

module mstb_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [mstb_pkg::STAT_W-1:0]   rsp_status,
   input logic [mstb_pkg::FIELD_W-1:0]  rsp_granted,
   input logic [mstb_pkg::FIELD_W-1:0]  rsp_tokens_left
);

   `MSTB_ASSERT_NEXT(a_rsp_follows, clock, reset, start && !busy, ##1 rsp_valid)
   `MSTB_ASSERT_IMPL(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, 2))
   `MSTB_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3)
   `MSTB_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid && (rsp_status != mstb_pkg::ST_OK), (rsp_granted == '0) && (rsp_tokens_left == '0))

endmodule

bind multi_slot_token_bucket mstb_port_checker u_mstb_port_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_granted     (rsp_granted),
   .rsp_tokens_left (rsp_tokens_left)
);

### test/mstb_checker.sv
// ----------------------------------------------------------------------------
// mstb_checker
// Watches the request and response ports of the token bucket table, keeps
// its own copy of the slot table, predicts one response per accepted request
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mstb_checker
   import mstb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [FIELD_W-1:0]  req_rate,
   input  logic [FIELD_W-1:0]  req_burst_limit,
   input  logic [FIELD_W-1:0]  req_request_size,
   input  logic                rsp_valid,
   input  logic [STAT_W-1:0]   rsp_status,
   input  logic [SLOT_W-1:0]   rsp_slot_out,
   input  logic [FIELD_W-1:0]  rsp_granted,
   input  logic [FIELD_W-1:0]  rsp_tokens_left,
   output int                  fail_count,
   output int                  pending
);

   typedef struct {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [FIELD_W-1:0]  granted;
      logic [FIELD_W-1:0]  tokens;
   } bucket_rsp_t;

   bucket_rsp_t         bucket_rsp_queue[$];
   logic                bkt_open   [SLOTS_DEF];
   logic [FIELD_W-1:0]  bkt_rate   [SLOTS_DEF];
   logic [FIELD_W-1:0]  bkt_burst  [SLOTS_DEF];
   logic [FIELD_W-1:0]  bkt_tokens [SLOTS_DEF];

   function automatic bucket_rsp_t apply_request(func_type f, logic [SLOT_W-1:0] s,
                                                 logic [FIELD_W-1:0] rate,
                                                 logic [FIELD_W-1:0] burst,
                                                 logic [FIELD_W-1:0] size);
      bucket_rsp_t     r;
      logic [FIELD_W:0] sum;
      logic            found;
      r.status  = ST_OK;
      r.slot    = s;
      r.granted = '0;
      r.tokens  = '0;
      found     = 1'b0;
      case (f)
         FUNC_TICK: begin
            for (int i = 0; i < SLOTS_DEF; i++) begin
               if (bkt_open[i]) begin
                  sum = {1'b0, bkt_tokens[i]} + {1'b0, bkt_rate[i]};
                  bkt_tokens[i] = (sum > {1'b0, bkt_burst[i]}) ? bkt_burst[i]
                                                               : sum[FIELD_W-1:0];
               end
            end
            if (bkt_open[s]) r.tokens = bkt_tokens[s];
         end
         FUNC_OPEN: begin
            for (int i = 0; i < SLOTS_DEF; i++) begin
               if (!found && !bkt_open[i]) begin
                  found         = 1'b1;
                  bkt_open[i]   = 1'b1;
                  bkt_rate[i]   = rate;
                  bkt_burst[i]  = burst;
                  bkt_tokens[i] = '0;
                  r.slot        = i[SLOT_W-1:0];
               end
            end
            if (!found) begin
               r.status = ST_FULL;
               r.slot   = '0;
            end
         end
         FUNC_CLOSE: begin
            if (!bkt_open[s]) r.status = ST_NOT_OPEN;
            else bkt_open[s] = 1'b0;
         end
         default: begin
            if (!bkt_open[s]) begin
               r.status = ST_NOT_OPEN;
            end else begin
               r.granted     = (size < bkt_tokens[s]) ? size : bkt_tokens[s];
               bkt_tokens[s] = bkt_tokens[s] - r.granted;
               r.tokens      = bkt_tokens[s];
            end
         end
      endcase
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      bucket_rsp_t want;
      if (reset) begin
         for (int i = 0; i < SLOTS_DEF; i++) bkt_open[i] = 1'b0;
         bucket_rsp_queue.delete();
         fail_count = 0;
      end else begin
         // compare before queuing: a response never belongs to this edge's request
         if (rsp_valid === 1'b1) begin
            if (bucket_rsp_queue.size() == 0) begin
               $error("response with no outstanding request");
               fail_count++;
            end else begin
               want = bucket_rsp_queue.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("slot_out", want.slot, rsp_slot_out);
               check_field("granted", want.granted, rsp_granted);
               check_field("tokens_left", want.tokens, rsp_tokens_left);
            end
         end
         if (start && !busy)
            bucket_rsp_queue.push_back(apply_request(func_type'(req_func), req_slot,
                                                     req_rate, req_burst_limit,
                                                     req_request_size));
      end
      pending = bucket_rsp_queue.size();
   end

endmodule

### test/tb_multi_slot_token_bucket.sv
// ----------------------------------------------------------------------------
// tb_multi_slot_token_bucket
// Drives tick, open, close and consume requests into the token bucket table:
// a directed opening that fills and overflows the table and hits the token
// extremes, then random traffic under three sender idle profiles. Checking
// is done by mstb_checker; this module only issues requests and decides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multi_slot_token_bucket;
   import mstb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 225;
   localparam logic [FIELD_W-1:0] TOKEN_MAX = '1;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic [FIELD_W-1:0]  req_rate = '0;
   logic [FIELD_W-1:0]  req_burst_limit = '0;
   logic [FIELD_W-1:0]  req_request_size = '0;
   logic                rsp_valid;
   logic [STAT_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_out;
   logic [FIELD_W-1:0]  rsp_granted;
   logic [FIELD_W-1:0]  rsp_tokens_left;
   int                  fail_count;
   int                  pending;
   int                  cycle_count = 0;
   int                  idle_pct = 0;

   multi_slot_token_bucket i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_slot         (req_slot),
      .req_rate         (req_rate),
      .req_burst_limit  (req_burst_limit),
      .req_request_size (req_request_size),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_granted      (rsp_granted),
      .rsp_tokens_left  (rsp_tokens_left)
   );

   mstb_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_slot         (req_slot),
      .req_rate         (req_rate),
      .req_burst_limit  (req_burst_limit),
      .req_request_size (req_request_size),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_granted      (rsp_granted),
      .rsp_tokens_left  (rsp_tokens_left),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // called and returns at a falling edge
   task automatic send_request(func_type f, logic [SLOT_W-1:0] s,
                               logic [FIELD_W-1:0] rate, logic [FIELD_W-1:0] burst,
                               logic [FIELD_W-1:0] size);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_func         <= f;
      req_slot         <= s;
      req_rate         <= rate;
      req_burst_limit  <= burst;
      req_request_size <= size;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] rand_tokens();
      logic [FIELD_W-1:0] v;
      case ($urandom_range(9))
         0:       v = '0;
         1:       v = TOKEN_MAX;
         2, 3, 4, 5: v = FIELD_W'($urandom_range(64));
         6, 7:    v = FIELD_W'($urandom_range(4095));
         default: v = FIELD_W'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [SLOT_W-1:0] rand_slot();
      return ($urandom_range(3) == 0) ? SLOT_W'($urandom_range(15))
                                      : SLOT_W'($urandom_range(7));
   endfunction

   initial begin
      int       sent;
      int       roll;
      int       run_len;
      func_type f;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, then extremes of rate, burst and request
      send_request(FUNC_TICK, 4'd0, TOKEN_MAX, TOKEN_MAX, TOKEN_MAX);
      send_request(FUNC_CONSUME, 4'd3, '0, '0, 20'd7);
      send_request(FUNC_CLOSE, 4'd15, '0, '0, '0);
      send_request(FUNC_OPEN, 4'd9, TOKEN_MAX, TOKEN_MAX, '0);
      send_request(FUNC_OPEN, 4'd0, '0, '0, TOKEN_MAX);
      send_request(FUNC_CONSUME, 4'd0, '0, '0, 20'd5);
      send_request(FUNC_TICK, 4'd0, '0, '0, '0);
      send_request(FUNC_TICK, 4'd0, '0, '0, '0);
      send_request(FUNC_CONSUME, 4'd0, '0, '0, TOKEN_MAX);
      send_request(FUNC_CONSUME, 4'd0, '0, '0, '0);
      send_request(FUNC_CLOSE, 4'd0, '0, '0, '0);
      // fill the table and overflow it
      repeat (15) send_request(FUNC_OPEN, 4'd0, 20'd3, 20'd10, '0);
      send_request(FUNC_OPEN, 4'd5, 20'd1, 20'd1, '0);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 27 : (phase == 1) ? 49 : 0;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
               run_len = $urandom_range(4, 17);
               repeat (run_len)
                  send_request(FUNC_OPEN, rand_slot(), rand_tokens(), rand_tokens(),
                               rand_tokens());
               sent += run_len;
            end else begin
               f = (roll < 28) ? FUNC_TICK : (roll < 46) ? FUNC_OPEN :
                   (roll < 60) ? FUNC_CLOSE : FUNC_CONSUME;
               send_request(f, rand_slot(), rand_tokens(), rand_tokens(), rand_tokens());
               sent++;
            end
         end
      end

      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
